@@ sv/ccfp_pkg.sv @@
`default_nettype none
package ccfp_pkg;

    localparam int unsigned POS_W = 17;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP = 16'h8000;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] HDR_BYTES = POS_W'(8);

    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SEQ_HI = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SEQ_LO = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HCRC_HI = POS_W'(6);
    localparam logic [POS_W-1:0] POS_HCRC_LO = POS_W'(7);

    localparam logic [2:0] ST_VALID = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR = 3'd1;
    localparam logic [2:0] ST_HDR_CRC = 3'd2;
    localparam logic [2:0] ST_SHORT_FRAME = 3'd3;
    localparam logic [2:0] ST_PAY_CRC = 3'd4;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [7:0]  frame_type;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
        logic [2:0]  status;
        logic        frame_done;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ sv/ccfp_if.sv @@
`default_nettype none
interface ccfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source(output valid, output data_byte, output frame_end, input ready);
    modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

interface ccfp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [2:0]  status;
    logic        frame_done;

    modport source(output valid, output payload_byte, output frame_type,
                   output sequence_res, output payload_length, output status,
                   output frame_done, input ready);
    modport sink(input valid, input payload_byte, input frame_type,
                 input sequence_res, input payload_length, input status,
                 input frame_done, output ready);
endinterface
`default_nettype wire

@@ sv/ccfp_frame_core.sv @@
`default_nettype none
module ccfp_frame_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_frame_end,
    output logic                  o_res_valid,
    output ccfp_pkg::t_result     o_res
);

    logic [ccfp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_seq, n_seq;
    logic [15:0] r_len, n_len;
    logic [15:0] r_chk, n_chk;
    logic        r_good, n_good;
    logic [2:0]  r_early, n_early;

    logic [ccfp_pkg::POS_W-1:0] pay_end;
    logic [ccfp_pkg::POS_W-1:0] count;
    logic [15:0] chk_full;
    logic        forward;
    logic [2:0]  status;

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        n_type = r_type;
        n_seq = r_seq;
        n_len = r_len;
        n_chk = r_chk;
        n_good = r_good;
        n_early = r_early;
        forward = 1'b0;
        status = ccfp_pkg::ST_VALID;
        pay_end = ccfp_pkg::HDR_BYTES + {1'b0, r_len};
        chk_full = {r_chk[15:8], i_data_byte};

        if (r_pos < ccfp_pkg::POS_HCRC_HI) begin
            n_crc = ccfp_pkg::crc_byte(r_crc, i_data_byte);
            case (r_pos)
                ccfp_pkg::POS_TYPE:   n_type = i_data_byte;
                ccfp_pkg::POS_SEQ_HI: n_seq = {i_data_byte, r_seq[7:0]};
                ccfp_pkg::POS_SEQ_LO: n_seq = {r_seq[15:8], i_data_byte};
                ccfp_pkg::POS_LEN_HI: n_len = {i_data_byte, r_len[7:0]};
                ccfp_pkg::POS_LEN_LO: n_len = {r_len[15:8], i_data_byte};
                default: ;
            endcase
        end else if (r_pos == ccfp_pkg::POS_HCRC_HI) begin
            n_chk = {i_data_byte, 8'h00};
        end else if (r_pos == ccfp_pkg::POS_HCRC_LO) begin
            n_chk = chk_full;
            n_good = (chk_full == r_crc);
            n_early = (chk_full == r_crc) ? ccfp_pkg::ST_VALID : ccfp_pkg::ST_HDR_CRC;
            n_crc = ccfp_pkg::CRC_INIT;
        end else if (r_good) begin
            if (r_pos < pay_end) begin
                n_crc = ccfp_pkg::crc_byte(r_crc, i_data_byte);
                forward = 1'b1;
            end else if (r_pos == pay_end) begin
                n_chk = {i_data_byte, 8'h00};
            end else if (r_pos == pay_end + ccfp_pkg::POS_W'(1)) begin
                n_chk = chk_full;
            end
        end

        count = (r_pos != ccfp_pkg::POS_MAX) ? r_pos + ccfp_pkg::POS_W'(1) : r_pos;
        n_pos = count;

        if (count < ccfp_pkg::HDR_BYTES) begin
            status = ccfp_pkg::ST_SHORT_HDR;
        end else if (!n_good) begin
            status = (n_early != ccfp_pkg::ST_VALID) ? n_early : ccfp_pkg::ST_HDR_CRC;
        end else if (count < pay_end + ccfp_pkg::POS_W'(2)) begin
            status = ccfp_pkg::ST_SHORT_FRAME;
        end else if (n_chk != n_crc && n_len != 16'h0000) begin
            status = ccfp_pkg::ST_PAY_CRC;
        end

        o_res_valid = i_frame_end || forward;
        if (i_frame_end) begin
            o_res.payload_byte = 8'h00;
            o_res.frame_type = n_type;
            o_res.sequence_res = n_seq;
            o_res.payload_length = n_len;
            o_res.status = status;
            o_res.frame_done = 1'b1;
        end else begin
            o_res.payload_byte = i_data_byte;
            o_res.frame_type = 8'h00;
            o_res.sequence_res = 16'h0000;
            o_res.payload_length = 16'h0000;
            o_res.status = ccfp_pkg::ST_VALID;
            o_res.frame_done = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_frame_end)) begin
            r_pos <= '0;
            r_crc <= ccfp_pkg::CRC_INIT;
            r_type <= '0;
            r_seq <= '0;
            r_len <= '0;
            r_chk <= '0;
            r_good <= 1'b0;
            r_early <= ccfp_pkg::ST_VALID;
        end else if (i_fire) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_type <= n_type;
            r_seq <= n_seq;
            r_len <= n_len;
            r_chk <= n_chk;
            r_good <= n_good;
            r_early <= n_early;
        end
    end

endmodule
`default_nettype wire

@@ sv/crc_checked_frame_parser.sv @@
// Checks byte-framed packets protected by CRC-16-CCITT and forwards the payload bytes
// of frames whose header CRC matches. One byte transfer is taken every cycle while the
// result side keeps up. A byte passes an input register and the frame core, whose
// byte-wide CRC update is the deepest logic. Its result is loaded into the output
// register when the byte leaves the input register. Each forwarded payload byte that
// is not final yields one result, each final byte one verdict result, others none.
`default_nettype none
module crc_checked_frame_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ccfp_in_if.sink     i_in,
    ccfp_out_if.source  o_res
);

    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_frame_end;

    logic               r_out_valid;
    ccfp_pkg::t_result  r_out;

    logic               out_free;
    logic               proc_fire;
    logic               core_valid;
    ccfp_pkg::t_result  core_res;

    assign out_free = !r_out_valid || o_res.ready;
    assign proc_fire = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data_byte <= i_in.data_byte;
            r_frame_end <= i_in.frame_end;
        end
    end

    ccfp_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc_fire),
        .i_data_byte (r_data_byte),
        .i_frame_end (r_frame_end),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire) begin
            r_out_valid <= core_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && core_valid) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.payload_byte = r_out.payload_byte;
    assign o_res.frame_type = r_out.frame_type;
    assign o_res.sequence_res = r_out.sequence_res;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.status = r_out.status;
    assign o_res.frame_done = r_out.frame_done;

endmodule
`default_nettype wire

@@ sv/ccfp_checker.sv @@
`default_nettype none
module ccfp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_payload_byte,
    input wire logic [7:0]  i_frame_type,
    input wire logic [15:0] i_sequence_res,
    input wire logic [15:0] i_payload_length,
    input wire logic [2:0]  i_status,
    input wire logic        i_frame_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_payload_byte)
            && $stable(i_status) && $stable(i_frame_done))
        else $error("Result changed while stalled.");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_status <= ccfp_pkg::ST_PAY_CRC)
        else $error("Verdict status out of range.");

    a_verdict_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> i_payload_byte == 8'h00)
        else $error("Verdict carries a payload byte.");

    a_byte_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_frame_done |-> i_frame_type == 8'h00
            && i_sequence_res == 16'h0000 && i_payload_length == 16'h0000
            && i_status == ccfp_pkg::ST_VALID)
        else $error("Payload result carries header fields.");

endmodule

bind crc_checked_frame_parser ccfp_checker u_ccfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_payload_byte   (o_res.payload_byte),
    .i_frame_type     (o_res.frame_type),
    .i_sequence_res   (o_res.sequence_res),
    .i_payload_length (o_res.payload_length),
    .i_status         (o_res.status),
    .i_frame_done     (o_res.frame_done)
);
`default_nettype wire

@@ tb/sv/ccfp_frame_checker.sv @@
`default_nettype none
package ccfp_tb_pkg;
    import ccfp_pkg::*;

    function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction
endpackage

module ccfp_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_byte_valid,
    input  wire logic        i_byte_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_end,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_ready,
    input  wire ccfp_pkg::t_result i_res,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ccfp_pkg::*;
    import ccfp_tb_pkg::*;

    t_result expected_results[$];
    int      fail_total = 0;

    logic [POS_W-1:0] frame_pos;
    logic [15:0]      frame_crc;
    logic [7:0]       hdr_type;
    logic [15:0]      hdr_seq;
    logic [15:0]      hdr_len;
    logic [15:0]      crc_field;
    logic             hdr_ok;
    logic [2:0]       hdr_verdict;

    logic [POS_W-1:0] pos_prev;
    logic [POS_W-1:0] payload_end;
    logic             forward_byte;
    logic [2:0]       verdict_status;
    t_result          next_res;
    t_result          oldest;

    task automatic clear_frame();
        frame_pos = '0;
        frame_crc = CRC_INIT;
        hdr_type = '0;
        hdr_seq = '0;
        hdr_len = '0;
        crc_field = '0;
        hdr_ok = 1'b0;
        hdr_verdict = ST_VALID;
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            fail_total++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        clear_frame();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time, i_res);
                    fail_total++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("payload_byte", 16'(oldest.payload_byte), 16'(i_res.payload_byte));
                    check_field("frame_type", 16'(oldest.frame_type), 16'(i_res.frame_type));
                    check_field("sequence_res", oldest.sequence_res, i_res.sequence_res);
                    check_field("payload_length", oldest.payload_length, i_res.payload_length);
                    check_field("status", 16'(oldest.status), 16'(i_res.status));
                    check_field("frame_done", 16'(oldest.frame_done), 16'(i_res.frame_done));
                end
            end

            if (i_byte_valid && i_byte_ready) begin
                pos_prev = frame_pos;
                payload_end = HDR_BYTES + POS_W'(hdr_len);
                forward_byte = 1'b0;

                if (pos_prev < POS_HCRC_HI) begin
                    frame_crc = crc16_ccitt_next(frame_crc, i_data_byte);
                    case (pos_prev)
                        POS_TYPE:   hdr_type = i_data_byte;
                        POS_SEQ_HI: hdr_seq[15:8] = i_data_byte;
                        POS_SEQ_LO: hdr_seq[7:0] = i_data_byte;
                        POS_LEN_HI: hdr_len[15:8] = i_data_byte;
                        POS_LEN_LO: hdr_len[7:0] = i_data_byte;
                        default: ;
                    endcase
                end else if (pos_prev == POS_HCRC_HI) begin
                    crc_field = {i_data_byte, 8'h00};
                end else if (pos_prev == POS_HCRC_LO) begin
                    crc_field[7:0] = i_data_byte;
                    hdr_ok = (crc_field == frame_crc);
                    hdr_verdict = hdr_ok ? ST_VALID : ST_HDR_CRC;
                    frame_crc = CRC_INIT;
                end else if (hdr_ok) begin
                    if (pos_prev < payload_end) begin
                        frame_crc = crc16_ccitt_next(frame_crc, i_data_byte);
                        forward_byte = 1'b1;
                    end else if (pos_prev == payload_end) begin
                        crc_field = {i_data_byte, 8'h00};
                    end else if (pos_prev == payload_end + POS_W'(1)) begin
                        crc_field[7:0] = i_data_byte;
                    end
                end

                if (frame_pos < POS_MAX) begin
                    frame_pos = frame_pos + POS_W'(1);
                end

                if (i_frame_end) begin
                    if (frame_pos < HDR_BYTES) begin
                        verdict_status = ST_SHORT_HDR;
                    end else if (!hdr_ok) begin
                        verdict_status = (hdr_verdict != ST_VALID) ? hdr_verdict : ST_HDR_CRC;
                    end else if (frame_pos < payload_end + POS_W'(2)) begin
                        verdict_status = ST_SHORT_FRAME;
                    end else if (crc_field != frame_crc && hdr_len != 16'h0000) begin
                        verdict_status = ST_PAY_CRC;
                    end else begin
                        verdict_status = ST_VALID;
                    end
                    next_res.payload_byte = 8'h00;
                    next_res.frame_type = hdr_type;
                    next_res.sequence_res = hdr_seq;
                    next_res.payload_length = hdr_len;
                    next_res.status = verdict_status;
                    next_res.frame_done = 1'b1;
                    expected_results = {expected_results, next_res};
                    clear_frame();
                end else if (forward_byte) begin
                    next_res = '0;
                    next_res.payload_byte = i_data_byte;
                    expected_results = {expected_results, next_res};
                end
            end
        end
        o_pending <= expected_results.size();
        o_fail_count <= fail_total;
    end
endmodule
`default_nettype wire

@@ tb/sv/crc_checked_frame_parser_test.sv @@
`default_nettype none
module crc_checked_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ccfp_pkg::*;
    import ccfp_tb_pkg::*;

    localparam int CYCLE_LIMIT = 100_000;
    localparam int RANDOM_BYTES = 1000;
    localparam int HOLD_START = 300;
    localparam int HOLD_CYCLES = 200;
    localparam int RX_QUIET_FIRST = 900;
    localparam int RX_QUIET_LAST = 1300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    ccfp_in_if  byte_if ();
    ccfp_out_if res_if ();

    crc_checked_frame_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_res   (res_if)
    );

    int fail_count;
    int pending;

    ccfp_frame_checker frame_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_if.valid),
        .i_byte_ready (byte_if.ready),
        .i_data_byte  (byte_if.data_byte),
        .i_frame_end  (byte_if.frame_end),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res        ({res_if.payload_byte, res_if.frame_type, res_if.sequence_res,
                        res_if.payload_length, res_if.status, res_if.frame_done}),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    logic [7:0] frame_bytes[$];
    logic       tx_quiet = 1'b0;
    int         bytes_sent = 0;

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("crc_checked_frame_parser_test NOT OK");
                $finish;
            end
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n) begin
                rx_cycle++;
            end
            if (rx_cycle == HOLD_START) begin
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (rx_cycle >= RX_QUIET_FIRST && rx_cycle <= RX_QUIET_LAST) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= 11);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!tx_quiet && $urandom_range(0, 99) < 11) begin
            byte_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.frame_end <= last;
        @(posedge i_clk);
        while (!byte_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic append_byte(input logic [7:0] b);
        frame_bytes = {frame_bytes, b};
    endtask

    task automatic start_frame(input logic [7:0] ftype, input logic [15:0] seq,
                               input logic [15:0] len, input logic [7:0] mode,
                               input logic corrupt);
        logic [15:0] crc;
        frame_bytes = {ftype, seq[15:8], seq[7:0], len[15:8], len[7:0], mode};
        crc = CRC_INIT;
        foreach (frame_bytes[i]) begin
            crc = crc16_ccitt_next(crc, frame_bytes[i]);
        end
        if (corrupt) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        append_byte(crc[15:8]);
        append_byte(crc[7:0]);
    endtask

    task automatic add_payload(input int n, input logic corrupt);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        repeat (n) begin
            b = 8'($urandom);
            append_byte(b);
            crc = crc16_ccitt_next(crc, b);
        end
        if (corrupt) begin
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        end
        append_byte(crc[15:8]);
        append_byte(crc[7:0]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) begin
            append_byte(8'($urandom));
        end
    endtask

    task automatic cut_frame(input int keep);
        while (frame_bytes.size() > keep) begin
            void'(frame_bytes.pop_back());
        end
    endtask

    task automatic random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            start_frame(8'($urandom), 16'($urandom), 16'(len), 8'($urandom), 1'b0);
            add_payload(len, $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                add_noise($urandom_range(1, 3));
            end
        end else if (kind < 75) begin
            start_frame(8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
            add_noise($urandom_range(0, 6));
        end else if (kind < 85) begin
            len = $urandom_range(0, 6);
            start_frame(8'($urandom), 16'($urandom), 16'(len), 8'($urandom), 1'b0);
            add_payload(len, 1'b0);
            cut_frame($urandom_range(1, frame_bytes.size() - 1));
        end else if (kind < 93) begin
            start_frame(8'($urandom), 16'($urandom), 16'($urandom_range(0, 8)),
                        8'($urandom), 1'b1);
            add_noise($urandom_range(0, 5));
        end else begin
            frame_bytes.delete();
            add_noise($urandom_range(1, 12));
        end
        send_frame();
    endtask

    initial begin
        int frame_index;
        byte_if.valid = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.frame_end = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        start_frame(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        cut_frame(1);
        send_frame();
        start_frame(8'hA5, 16'hFFFF, 16'h8001, 8'h00, 1'b0);
        cut_frame(5);
        send_frame();
        start_frame(8'h3C, 16'h1234, 16'h0002, 8'h00, 1'b1);
        add_payload(2, 1'b0);
        send_frame();
        start_frame(8'h00, 16'h0000, 16'h0000, 8'h00, 1'b0);
        add_payload(0, 1'b1);
        send_frame();
        start_frame(8'hFF, 16'hFFFF, 16'h0001, 8'hFF, 1'b0);
        add_payload(1, 1'b0);
        send_frame();
        start_frame(8'h7E, 16'h0001, 16'h0003, 8'h01, 1'b0);
        add_payload(3, 1'b1);
        send_frame();
        start_frame(8'h11, 16'h2222, 16'h0004, 8'h00, 1'b0);
        add_payload(4, 1'b0);
        cut_frame(10);
        send_frame();
        start_frame(8'h22, 16'h8000, 16'h0002, 8'h7F, 1'b0);
        add_payload(2, 1'b0);
        cut_frame(frame_bytes.size() - 1);
        send_frame();
        start_frame(8'h80, 16'h00FF, 16'h0001, 8'h80, 1'b0);
        add_payload(1, 1'b0);
        add_noise(3);
        send_frame();
        start_frame(8'h01, 16'hFF00, 16'h0000, 8'h01, 1'b0);
        send_frame();
        wait_drained();

        frame_index = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            tx_quiet = (frame_index >= 20 && frame_index < 30);
            random_frame();
            frame_index++;
            if (frame_index % 15 == 0) begin
                wait_drained();
            end
        end
        tx_quiet = 1'b0;

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("crc_checked_frame_parser_test OK");
        end else begin
            $display("crc_checked_frame_parser_test NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
